// ===== rtl/core/asa_pkg.sv =====
// aged slot allocator package: widths, table size, register indexes, state codes
// and the saturating time add; used by the interfaces and the top level
`default_nettype none

package asa_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int TIME_W     = 32;
  localparam int IDX_W      = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_REUSE_DELAY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_HORIZON = 1'd1;

  localparam logic [TIME_W-1:0] REUSE_DELAY_RST    = 32'd1000;
  localparam logic [TIME_W-1:0] SEARCH_HORIZON_RST = 32'd100000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_COMMIT = 4'b1000
  } asa_state_t;

  typedef struct packed {
    logic              active;
    logic [TIME_W-1:0] free_time;
  } asa_slot_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/asa_if.sv =====
// item channels of the aged slot allocator: request and result
// depends on asa_pkg for the field widths
`default_nettype none

interface asa_in_if import asa_pkg::*;;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [TIME_W-1:0] current_time;
  logic [IDX_W-1:0]  slot_index;

  modport source (output valid, output opcode, output current_time, output slot_index,
                  input ready);
  modport sink   (input valid, input opcode, input current_time, input slot_index,
                  output ready);
endinterface

interface asa_out_if import asa_pkg::*;;
  logic             valid;
  logic             ready;
  logic             granted;
  logic [IDX_W-1:0] result_slot;

  modport source (output valid, output granted, output result_slot, input ready);
  modport sink   (input valid, input granted, input result_slot, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/aged_slot_allocator_unit.sv =====
// aged slot allocator top level: slot table memory, scan sequencer, output register
// depends on asa_pkg and the channel interfaces in asa_if.sv
`default_nettype none

// After reset the block clears its slot table, one entry a cycle, through all SLOT_COUNT
// (1024) entries and takes no item meanwhile; configuration writes are taken at any
// time. One item is worked on at a time. A free item goes from acceptance straight to
// the commit state, which loads its result. An allocate item reads the table one slot
// per cycle through the single read port and stops at the first inactive expired slot,
// or scans the whole table when there is none. A new item is accepted while a result
// still waits in the output register; the item after it holds in its commit state
// until that result is taken.
module aged_slot_allocator_unit import asa_pkg::*; (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire [CFG_IDX_W-1:0] cfg_idx,
  input  wire [CFG_W-1:0]     cfg_data,
  asa_in_if.sink              in_ch,
  asa_out_if.source           out_ch
);

  asa_slot_t mem [SLOT_COUNT];
  asa_slot_t rd_data_r;

  asa_state_t state_r, state_nxt;

  logic [TIME_W-1:0] reuse_delay_r, search_horizon_r;
  logic [SLOT_W:0]   addr_r, addr_nxt;
  logic              vld_r, vld_nxt;
  logic [SLOT_W-1:0] chk_r, chk_nxt;
  logic [TIME_W-1:0] bound_r, bound_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [SLOT_W-1:0] pick_r, pick_nxt;
  logic              found_r, found_nxt;
  logic              op_r, op_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_granted_r, out_granted_nxt;
  logic [IDX_W-1:0]  out_slot_r, out_slot_nxt;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  asa_slot_t         wr_data;
  logic [SLOT_W-1:0] rd_addr;
  logic              accept, out_free, idx_ok, qualify;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;
  assign idx_ok             = (32'(in_ch.slot_index) < 32'(SLOT_COUNT));
  assign rd_addr            = addr_r[SLOT_W-1:0];
  assign qualify            = vld_r && !rd_data_r.active && (rd_data_r.free_time < bound_r);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.granted     = out_granted_r;
  assign out_ch.result_slot = out_slot_r;

  // slot table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt       = state_r;
    addr_nxt        = addr_r;
    vld_nxt         = 1'b0;
    chk_nxt         = chk_r;
    bound_nxt       = bound_r;
    now_nxt         = now_r;
    pick_nxt        = pick_r;
    found_nxt       = found_r;
    op_nxt          = op_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_granted_nxt = out_granted_r;
    out_slot_nxt    = out_slot_r;
    wr_en           = 1'b0;
    wr_addr         = addr_r[SLOT_W-1:0];
    wr_data         = '0;
    case (state_r)
      ST_CLEAR: begin
        wr_en    = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == (SLOT_W+1)'(SLOT_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_ch.opcode;
          now_nxt  = in_ch.current_time;
          addr_nxt = '0;
          if (in_ch.opcode == OP_FREE) begin
            bound_nxt = sat_add(in_ch.current_time, reuse_delay_r);
            pick_nxt  = SLOT_W'(in_ch.slot_index);
            found_nxt = idx_ok;
            state_nxt = ST_COMMIT;
          end else begin
            bound_nxt = sat_add(in_ch.current_time, search_horizon_r);
            pick_nxt  = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, check the data of the previous read
        if (addr_r != (SLOT_W+1)'(SLOT_COUNT)) begin
          vld_nxt  = 1'b1;
          chk_nxt  = addr_r[SLOT_W-1:0];
          addr_nxt = addr_r + 1'b1;
        end
        if (qualify) begin
          bound_nxt = rd_data_r.free_time;
          pick_nxt  = chk_r;
          found_nxt = 1'b1;
          if (rd_data_r.free_time < now_r) begin
            state_nxt = ST_COMMIT;
            vld_nxt   = 1'b0;
          end
        end else if (!vld_r && addr_r == (SLOT_W+1)'(SLOT_COUNT)) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          wr_en             = found_r;
          wr_addr           = pick_r;
          wr_data.active    = (op_r == OP_ALLOC);
          wr_data.free_time = bound_r;
          out_valid_nxt     = 1'b1;
          out_granted_nxt   = found_r;
          out_slot_nxt      = found_r ? IDX_W'(pick_r) : '0;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      addr_r           <= '0;
      vld_r            <= 1'b0;
      out_valid_r      <= 1'b0;
      reuse_delay_r    <= REUSE_DELAY_RST;
      search_horizon_r <= SEARCH_HORIZON_RST;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_REUSE_DELAY:    reuse_delay_r    <= cfg_data;
          REG_SEARCH_HORIZON: search_horizon_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_r         <= chk_nxt;
    bound_r       <= bound_nxt;
    now_r         <= now_nxt;
    pick_r        <= pick_nxt;
    found_r       <= found_nxt;
    op_r          <= op_nxt;
    out_granted_r <= out_granted_nxt;
    out_slot_r    <= out_slot_nxt;
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register not one-hot");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !wr_en)
    else $error("table written during a scan");

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_granted_r) |-> (out_slot_r == '0))
    else $error("failed item carries a nonzero slot");

  a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_COMMIT)
    else $error("result loaded outside commit");

endmodule

`default_nettype wire
